// ===== hdl/tmr_pkg.sv =====
// Shared constants, codes and types of the track motion refinement block.
// Depends on nothing; every other file imports it.
`default_nettype none

package tmr_pkg;

    localparam int VEL_WIDTH_DEF  = 24;
    localparam int TIME_WIDTH_DEF = 32;

    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int PED_WIDTH       = 2;
    localparam int ACTION_WIDTH    = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPEED_THR = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACCEL_THR = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_DT    = 2'd2;

    localparam logic [CFG_WIDTH-1:0] SPEED_THR_RST = 16'd256;
    localparam logic [CFG_WIDTH-1:0] ACCEL_THR_RST = 16'd1280;
    localparam logic [CFG_WIDTH-1:0] MIN_DT_RST    = 16'd1;

    // time step carries 16 fraction bits, squared: 2^32; halved threshold: 2^34
    localparam int ACC_SHIFT      = 32;
    localparam int ACC_HALF_SHIFT = 34;

    // speed levels V/8, V/4, V/2 compared as squares
    localparam int LVL8_SHIFT = 6;
    localparam int LVL4_SHIFT = 4;
    localparam int LVL2_SHIFT = 2;

    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_UNCHANGED = 2'd0,
        ACT_KEEP      = 2'd1,
        ACT_ZERO      = 2'd2
    } t_action;

    // pipeline stages, register k loads on en[k]
    localparam int N_STAGES  = 8;
    localparam int ST_MUL    = 0;
    localparam int ST_SUM    = 1;
    localparam int ST_ABS    = 2;
    localparam int ST_PROD_A = 3;
    localparam int ST_PROD_B = 4;
    localparam int ST_DIFF   = 5;
    localparam int ST_CMP    = 6;
    localparam int ST_OUT    = 7;

    typedef struct packed {
        logic [N_STAGES-1:0] en;
        logic [N_STAGES-1:0] vld;
        logic                in_ready;
    } t_pipe_ctl;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] speed_thr;
        logic [CFG_WIDTH-1:0] accel_thr;
        logic [CFG_WIDTH-1:0] min_dt;
    } t_cfg;

    typedef struct packed {
        logic narrow;
        logic wide;
    } t_angle_flags;

endpackage

`default_nettype wire

// ===== hdl/tmr_in_if.sv =====
// Input channel of the track motion refinement block: one track update per item.
// Depends on tmr_pkg for default widths.
`default_nettype none

interface tmr_in_if #(
    parameter int VEL_WIDTH  = tmr_pkg::VEL_WIDTH_DEF,
    parameter int TIME_WIDTH = tmr_pkg::TIME_WIDTH_DEF
);
    logic                               valid;
    logic                               ready;
    logic signed [TIME_WIDTH-1:0]       time_delta;
    logic signed [VEL_WIDTH-1:0]        gain_x;
    logic signed [VEL_WIDTH-1:0]        gain_y;
    logic signed [VEL_WIDTH-1:0]        gain_z;
    logic signed [VEL_WIDTH-1:0]        new_velocity_x;
    logic signed [VEL_WIDTH-1:0]        new_velocity_y;
    logic signed [VEL_WIDTH-1:0]        prev_velocity_x;
    logic signed [VEL_WIDTH-1:0]        prev_velocity_y;
    logic signed [VEL_WIDTH-1:0]        prev_direction_x;
    logic signed [VEL_WIDTH-1:0]        prev_direction_y;
    logic [tmr_pkg::PED_WIDTH-1:0]      pedestrian_flags;
    logic                               converged;

    modport source (
        output valid, time_delta, gain_x, gain_y, gain_z,
               new_velocity_x, new_velocity_y, prev_velocity_x, prev_velocity_y,
               prev_direction_x, prev_direction_y, pedestrian_flags, converged,
        input  ready
    );

    modport sink (
        input  valid, time_delta, gain_x, gain_y, gain_z,
               new_velocity_x, new_velocity_y, prev_velocity_x, prev_velocity_y,
               prev_direction_x, prev_direction_y, pedestrian_flags, converged,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/tmr_out_if.sv =====
// Output channel of the track motion refinement block: one decision per item.
// Depends on tmr_pkg for default widths and the action code width.
`default_nettype none

interface tmr_out_if #(
    parameter int VEL_WIDTH = tmr_pkg::VEL_WIDTH_DEF
);
    logic                               valid;
    logic                               ready;
    logic [tmr_pkg::ACTION_WIDTH-1:0]   action;
    logic signed [VEL_WIDTH-1:0]        out_velocity_x;
    logic signed [VEL_WIDTH-1:0]        out_velocity_y;

    modport source (
        output valid, action, out_velocity_x, out_velocity_y,
        input  ready
    );

    modport sink (
        input  valid, action, out_velocity_x, out_velocity_y,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/tmr_ctrl.sv =====
// Valid and stall control of the refinement pipeline; a stage loads when it is
// empty or its successor loads. Depends on tmr_pkg.
`default_nettype none

module tmr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output tmr_pkg::t_pipe_ctl o_ctl
);
    import tmr_pkg::*;

    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] w_en;

    always_comb begin
        w_en[N_STAGES-1] = !r_vld[N_STAGES-1] || i_out_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        o_ctl.en       = w_en;
        o_ctl.vld      = r_vld;
        o_ctl.in_ready = w_en[0];
    end

endmodule

`default_nettype wire

// ===== hdl/tmr_wmul.sv =====
// Two-stage unsigned multiplier: half-width partial products, then their sum.
// Depends on tmr_pkg for default widths.
`default_nettype none

module tmr_wmul #(
    parameter int A_WIDTH = 2 * tmr_pkg::VEL_WIDTH_DEF,
    parameter int B_WIDTH = 2 * tmr_pkg::VEL_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic [1:0]                 i_en,
    input  logic [A_WIDTH-1:0]         i_a,
    input  logic [B_WIDTH-1:0]         i_b,
    output logic [A_WIDTH+B_WIDTH-1:0] o_p
);
    localparam int AL   = A_WIDTH / 2;
    localparam int AH   = A_WIDTH - AL;
    localparam int BL   = B_WIDTH / 2;
    localparam int BH   = B_WIDTH - BL;
    localparam int PWID = A_WIDTH + B_WIDTH;

    logic [AL+BL-1:0] r_ll;
    logic [AL+BH-1:0] r_lh;
    logic [AH+BL-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [PWID-1:0]  r_p;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ll <= i_a[AL-1:0] * i_b[BL-1:0];
            r_lh <= i_a[AL-1:0] * i_b[B_WIDTH-1:BL];
            r_hl <= i_a[A_WIDTH-1:AL] * i_b[BL-1:0];
            r_hh <= i_a[A_WIDTH-1:AL] * i_b[B_WIDTH-1:BL];
        end
        if (i_en[1]) begin
            r_p <= (PWID'(r_hh) << (AL + BL)) + (PWID'(r_hl) << AL)
                 + (PWID'(r_lh) << BL) + PWID'(r_ll);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== hdl/tmr_angle.sv =====
// Angle-change tests at 30 and 45 degrees on squared dot products, stages
// ST_ABS to ST_CMP. Depends on tmr_pkg and tmr_wmul.
`default_nettype none

module tmr_angle #(
    parameter int VEL_WIDTH = tmr_pkg::VEL_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  tmr_pkg::t_pipe_ctl          i_ctl,
    input  logic [2*VEL_WIDTH-1:0]      i_psq,
    input  logic [2*VEL_WIDTH-1:0]      i_csq,
    input  logic [2*VEL_WIDTH-1:0]      i_hsq,
    input  logic signed [2*VEL_WIDTH:0] i_dp,
    input  logic signed [2*VEL_WIDTH:0] i_dh,
    output tmr_pkg::t_angle_flags       o_flags
);
    import tmr_pkg::*;

    localparam int PW  = 2 * VEL_WIDTH;
    localparam int DW  = PW + 1;
    localparam int PRW = 2 * PW;
    localparam int TW3 = PRW + 2;

    logic [PW-1:0]  r_psq;
    logic [PW-1:0]  r_csq;
    logic [PW-1:0]  r_hsq;
    logic [PW-1:0]  r_dpm;
    logic [PW-1:0]  r_dhm;
    logic           r_ok [ST_ABS:ST_DIFF];
    logic [PRW-1:0] w_pc;
    logic [PRW-1:0] w_hc;
    logic [PRW-1:0] w_ddp;
    logic [PRW-1:0] w_ddh;
    logic [PRW-1:0] r_dfp;
    logic [PRW-1:0] r_dfh;
    logic [PRW-1:0] r_ddp;
    logic [PRW-1:0] r_ddh;
    logic           w_bpn;
    logic           w_bpw;
    logic           w_bhn;
    logic           w_bhw;
    t_angle_flags   r_flags;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_ABS]) begin
            r_psq        <= i_psq;
            r_csq        <= i_csq;
            r_hsq        <= i_hsq;
            r_dpm        <= i_dp[DW-1] ? PW'(-i_dp) : PW'(i_dp);
            r_dhm        <= i_dh[DW-1] ? PW'(-i_dh) : PW'(i_dh);
            r_ok[ST_ABS] <= (i_psq != '0) && (i_csq != '0)
                         && !i_dp[DW-1] && (i_dp != '0);
        end
        for (int k = ST_PROD_A; k <= ST_DIFF; k++) begin
            if (i_ctl.en[k]) begin
                r_ok[k] <= r_ok[k-1];
            end
        end
        if (i_ctl.en[ST_DIFF]) begin
            r_dfp <= w_pc - w_ddp;
            r_dfh <= w_hc - w_ddh;
            r_ddp <= w_ddp;
            r_ddh <= w_ddh;
        end
        if (i_ctl.en[ST_CMP]) begin
            r_flags.narrow <= !r_ok[ST_DIFF] || w_bpn || w_bhn;
            r_flags.wide   <= !r_ok[ST_DIFF] || w_bpw || w_bhw;
        end
    end

    tmr_wmul #(.A_WIDTH(PW), .B_WIDTH(PW)) u_mul_pc (
        .i_clk (i_clk),
        .i_en  ({i_ctl.en[ST_PROD_B], i_ctl.en[ST_PROD_A]}),
        .i_a   (r_psq),
        .i_b   (r_csq),
        .o_p   (w_pc)
    );

    tmr_wmul #(.A_WIDTH(PW), .B_WIDTH(PW)) u_mul_hc (
        .i_clk (i_clk),
        .i_en  ({i_ctl.en[ST_PROD_B], i_ctl.en[ST_PROD_A]}),
        .i_a   (r_hsq),
        .i_b   (r_csq),
        .o_p   (w_hc)
    );

    tmr_wmul #(.A_WIDTH(PW), .B_WIDTH(PW)) u_mul_ddp (
        .i_clk (i_clk),
        .i_en  ({i_ctl.en[ST_PROD_B], i_ctl.en[ST_PROD_A]}),
        .i_a   (r_dpm),
        .i_b   (r_dpm),
        .o_p   (w_ddp)
    );

    tmr_wmul #(.A_WIDTH(PW), .B_WIDTH(PW)) u_mul_ddh (
        .i_clk (i_clk),
        .i_en  ({i_ctl.en[ST_PROD_B], i_ctl.en[ST_PROD_A]}),
        .i_a   (r_dhm),
        .i_b   (r_dhm),
        .o_p   (w_ddh)
    );

    // 30 degrees: 3 * (|a|^2 |b|^2 - dot^2) > dot^2; 45 degrees without the 3
    always_comb begin
        w_bpn = (TW3'(r_dfp) + (TW3'(r_dfp) << 1)) > TW3'(r_ddp);
        w_bhn = (TW3'(r_dfh) + (TW3'(r_dfh) << 1)) > TW3'(r_ddh);
        w_bpw = r_dfp > r_ddp;
        w_bhw = r_dfh > r_ddh;
    end

    assign o_flags = r_flags;

endmodule

`default_nettype wire

// ===== hdl/track_motion_refine_core.sv =====
// Track motion refinement: decides keep, zero or unchanged output velocity for
// each track update. One item is accepted per clock when the output is taken.
// The depth is set by the two-stage split squarings of the angle tests (48 x 48
// bits at the default velocity width) followed by the subtract and the
// triple-and-compare stage. Stalled results hold in the output register while
// empty stages keep taking items. The user is to write registers through the
// configuration port only while idle; the block itself does not enforce it.
// Depends on tmr_pkg, tmr_in_if, tmr_out_if, tmr_ctrl, tmr_wmul and tmr_angle.
`default_nettype none

module track_motion_refine_core #(
    parameter int VEL_WIDTH  = tmr_pkg::VEL_WIDTH_DEF,
    parameter int TIME_WIDTH = tmr_pkg::TIME_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [tmr_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [tmr_pkg::CFG_WIDTH-1:0]         i_cfg_data,
    tmr_in_if.sink                                i_in,
    tmr_out_if.source                             o_out
);
    import tmr_pkg::*;

    localparam int PW    = 2 * VEL_WIDTH;
    localparam int SQW   = PW - 1;
    localparam int DW    = PW + 1;
    localparam int ATW   = CFG_WIDTH + TIME_WIDTH - 1;
    localparam int AT2W  = 2 * ATW;
    localparam int KW    = (PW + ACC_HALF_SHIFT > AT2W) ? PW + ACC_HALF_SHIFT : AT2W;
    localparam int VSQW  = 2 * CFG_WIDTH;
    localparam int LW    = (PW + LVL8_SHIFT > VSQW) ? PW + LVL8_SHIFT : VSQW;
    localparam int CMPW  = TIME_WIDTH + CFG_WIDTH;
    localparam int SIDEW = 4 * VEL_WIDTH + 3;

    t_cfg         r_cfg;
    t_pipe_ctl    ctl;
    t_angle_flags w_ang;

    logic signed [PW-1:0] n_gsq_x, n_gsq_y, n_gsq_z;
    logic signed [PW-1:0] n_nsq_x, n_nsq_y, n_psq_x, n_psq_y, n_hsq_x, n_hsq_y;
    logic signed [PW-1:0] n_pd_x, n_pd_y, n_hd_x, n_hd_y;
    logic                 n_tok;
    logic [SIDEW-1:0]     n_side;

    logic [SQW-1:0]        r_gsq_x, r_gsq_y, r_gsq_z;
    logic [SQW-1:0]        r_nsq_x, r_nsq_y, r_psq_x, r_psq_y, r_hsq_x, r_hsq_y;
    logic signed [PW-1:0]  r_pd_x, r_pd_y, r_hd_x, r_hd_y;
    logic [ATW-1:0]        r_at;
    logic                  r_tok [ST_MUL:ST_ABS];
    logic [VSQW-1:0]       r_vsq [ST_MUL:ST_SUM];
    logic [SIDEW-1:0]      r_side [ST_MUL:ST_CMP];

    logic [PW-1:0]         r_g2;
    logic [PW-1:0]         r_g2b;
    logic [PW-1:0]         r_csq, r_psq, r_hsq;
    logic signed [DW-1:0]  r_dp, r_dh;
    logic [AT2W-1:0]       w_at2;

    logic [3:0]            r_lvl [ST_ABS:ST_CMP];
    logic                  r_keep [ST_PROD_A:ST_CMP];
    logic                  n_keep;

    t_action               r_action;
    logic signed [VEL_WIDTH-1:0] r_out_vx, r_out_vy;

    logic signed [VEL_WIDTH-1:0] w_nvx, w_nvy, w_pvx, w_pvy;
    logic                  w_pp, w_conv, w_zero;
    logic                  w_lz0, w_lz1, w_lz2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{speed_thr: SPEED_THR_RST, accel_thr: ACCEL_THR_RST,
                       min_dt: MIN_DT_RST};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SPEED_THR: r_cfg.speed_thr <= i_cfg_data;
                REG_ACCEL_THR: r_cfg.accel_thr <= i_cfg_data;
                REG_MIN_DT:    r_cfg.min_dt    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_ctl       (ctl)
    );

    assign i_in.ready = ctl.in_ready;

    always_comb begin
        n_gsq_x = i_in.gain_x * i_in.gain_x;
        n_gsq_y = i_in.gain_y * i_in.gain_y;
        n_gsq_z = i_in.gain_z * i_in.gain_z;
        n_nsq_x = i_in.new_velocity_x * i_in.new_velocity_x;
        n_nsq_y = i_in.new_velocity_y * i_in.new_velocity_y;
        n_psq_x = i_in.prev_velocity_x * i_in.prev_velocity_x;
        n_psq_y = i_in.prev_velocity_y * i_in.prev_velocity_y;
        n_hsq_x = i_in.prev_direction_x * i_in.prev_direction_x;
        n_hsq_y = i_in.prev_direction_y * i_in.prev_direction_y;
        n_pd_x  = i_in.prev_velocity_x * i_in.new_velocity_x;
        n_pd_y  = i_in.prev_velocity_y * i_in.new_velocity_y;
        n_hd_x  = i_in.prev_direction_x * i_in.new_velocity_x;
        n_hd_y  = i_in.prev_direction_y * i_in.new_velocity_y;
        // negative time steps never exceed the threshold
        n_tok   = !i_in.time_delta[TIME_WIDTH-1]
               && (CMPW'(i_in.time_delta[TIME_WIDTH-2:0]) >= CMPW'(r_cfg.min_dt));
        n_side  = {i_in.new_velocity_x, i_in.new_velocity_y,
                   i_in.prev_velocity_x, i_in.prev_velocity_y,
                   i_in.pedestrian_flags[1], i_in.pedestrian_flags[0], i_in.converged};
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[ST_MUL]) begin
            r_gsq_x        <= n_gsq_x[SQW-1:0];
            r_gsq_y        <= n_gsq_y[SQW-1:0];
            r_gsq_z        <= n_gsq_z[SQW-1:0];
            r_nsq_x        <= n_nsq_x[SQW-1:0];
            r_nsq_y        <= n_nsq_y[SQW-1:0];
            r_psq_x        <= n_psq_x[SQW-1:0];
            r_psq_y        <= n_psq_y[SQW-1:0];
            r_hsq_x        <= n_hsq_x[SQW-1:0];
            r_hsq_y        <= n_hsq_y[SQW-1:0];
            r_pd_x         <= n_pd_x;
            r_pd_y         <= n_pd_y;
            r_hd_x         <= n_hd_x;
            r_hd_y         <= n_hd_y;
            r_at           <= ATW'(r_cfg.accel_thr) * ATW'(i_in.time_delta[TIME_WIDTH-2:0]);
            r_tok[ST_MUL]  <= n_tok;
            r_vsq[ST_MUL]  <= VSQW'(r_cfg.speed_thr) * VSQW'(r_cfg.speed_thr);
            r_side[ST_MUL] <= n_side;
        end
        for (int k = ST_SUM; k <= ST_CMP; k++) begin
            if (ctl.en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
        if (ctl.en[ST_SUM]) begin
            r_g2          <= PW'(r_gsq_x) + PW'(r_gsq_y) + PW'(r_gsq_z);
            r_csq         <= PW'(r_nsq_x) + PW'(r_nsq_y);
            r_psq         <= PW'(r_psq_x) + PW'(r_psq_y);
            r_hsq         <= PW'(r_hsq_x) + PW'(r_hsq_y);
            r_dp          <= DW'(r_pd_x) + DW'(r_pd_y);
            r_dh          <= DW'(r_hd_x) + DW'(r_hd_y);
            r_tok[ST_SUM] <= r_tok[ST_MUL];
            r_vsq[ST_SUM] <= r_vsq[ST_MUL];
        end
        if (ctl.en[ST_ABS]) begin
            r_g2b         <= r_g2;
            r_tok[ST_ABS] <= r_tok[ST_SUM];
            r_lvl[ST_ABS] <= {(LW'(r_csq) << LVL8_SHIFT) < LW'(r_vsq[ST_SUM]),
                              (LW'(r_csq) << LVL4_SHIFT) < LW'(r_vsq[ST_SUM]),
                              (LW'(r_csq) << LVL2_SHIFT) < LW'(r_vsq[ST_SUM]),
                              LW'(r_csq) < LW'(r_vsq[ST_SUM])};
        end
        if (ctl.en[ST_PROD_A]) begin
            r_keep[ST_PROD_A] <= n_keep;
        end
        for (int k = ST_PROD_A; k <= ST_CMP; k++) begin
            if (ctl.en[k]) begin
                r_lvl[k] <= r_lvl[k-1];
            end
        end
        for (int k = ST_PROD_B; k <= ST_CMP; k++) begin
            if (ctl.en[k]) begin
                r_keep[k] <= r_keep[k-1];
            end
        end
        if (ctl.en[ST_OUT]) begin
            if (r_keep[ST_CMP] && !w_conv) begin
                r_action <= ACT_KEEP;
                r_out_vx <= w_pvx;
                r_out_vy <= w_pvy;
            end else if (w_zero) begin
                r_action <= ACT_ZERO;
                r_out_vx <= '0;
                r_out_vy <= '0;
            end else begin
                r_action <= ACT_UNCHANGED;
                r_out_vx <= w_nvx;
                r_out_vy <= w_nvy;
            end
        end
    end

    tmr_wmul #(.A_WIDTH(ATW), .B_WIDTH(ATW)) u_mul_at2 (
        .i_clk (i_clk),
        .i_en  ({ctl.en[ST_ABS], ctl.en[ST_SUM]}),
        .i_a   (r_at),
        .i_b   (r_at),
        .o_p   (w_at2)
    );

    // |gain|^2 * 2^32 > (A*T)^2, or 2^34 against the halved pedestrian threshold
    always_comb begin
        n_keep = r_tok[ST_ABS]
              && (((KW'(r_g2b) << ACC_SHIFT) > KW'(w_at2))
               || (r_side[ST_ABS][1] && ((KW'(r_g2b) << ACC_HALF_SHIFT) > KW'(w_at2))));
    end

    tmr_angle #(.VEL_WIDTH(VEL_WIDTH)) u_angle (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_psq   (r_psq),
        .i_csq   (r_csq),
        .i_hsq   (r_hsq),
        .i_dp    (r_dp),
        .i_dh    (r_dh),
        .o_flags (w_ang)
    );

    always_comb begin
        w_nvx  = r_side[ST_CMP][SIDEW-1 -: VEL_WIDTH];
        w_nvy  = r_side[ST_CMP][SIDEW-VEL_WIDTH-1 -: VEL_WIDTH];
        w_pvx  = r_side[ST_CMP][SIDEW-2*VEL_WIDTH-1 -: VEL_WIDTH];
        w_pvy  = r_side[ST_CMP][SIDEW-3*VEL_WIDTH-1 -: VEL_WIDTH];
        w_pp   = r_side[ST_CMP][2];
        w_conv = r_side[ST_CMP][0];
        // promote each speed level by one step unless the previous object walks
        w_lz0  = r_lvl[ST_CMP][3] || (r_lvl[ST_CMP][2] && !w_pp);
        w_lz1  = r_lvl[ST_CMP][2] || (r_lvl[ST_CMP][1] && !w_pp);
        w_lz2  = r_lvl[ST_CMP][1] || (r_lvl[ST_CMP][0] && !w_pp);
        w_zero = w_lz0 || (w_lz1 && w_ang.narrow) || (w_lz2 && w_ang.wide);
    end

    assign o_out.valid          = ctl.vld[ST_OUT];
    assign o_out.action         = r_action;
    assign o_out.out_velocity_x = r_out_vx;
    assign o_out.out_velocity_y = r_out_vy;

    a_en_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((ctl.en >> 1) & ~ctl.en) == '0)
        else $error("stage loads while its predecessor holds");

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!(&ctl.vld) || o_out.ready))
        else $error("item taken with a full stalled pipeline");

    a_keep_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.en[ST_PROD_A] && !r_tok[ST_ABS] |=> !r_keep[ST_PROD_A])
        else $error("keep raised for a rejected time step");

    a_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.action == ACT_ZERO)
            |-> (o_out.out_velocity_x == '0) && (o_out.out_velocity_y == '0))
        else $error("zero action with nonzero velocity");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for track_motion_refine_core: directed and random track updates,
// each decision checked against a listed result or a bit-exact refinement predictor.
// Depends on tmr_pkg, tmr_in_if, tmr_out_if and the core RTL.

module testbench;
    import tmr_pkg::*;

    localparam int VW = VEL_WIDTH_DEF;
    localparam int TW = TIME_WIDTH_DEF;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 140;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 12;
    localparam longint VEL_MAX   = (64'sd1 <<< (VW - 1)) - 1;

    typedef logic signed [VW-1:0] t_vel;
    typedef logic signed [TW-1:0] t_time;

    typedef struct {
        t_time                time_delta;
        t_vel                 gain_x;
        t_vel                 gain_y;
        t_vel                 gain_z;
        t_vel                 new_velocity_x;
        t_vel                 new_velocity_y;
        t_vel                 prev_velocity_x;
        t_vel                 prev_velocity_y;
        t_vel                 prev_direction_x;
        t_vel                 prev_direction_y;
        logic [PED_WIDTH-1:0] pedestrian_flags;
        logic                 converged;
    } t_update;

    typedef struct {
        t_action action;
        t_vel    vx;
        t_vel    vy;
    } t_decision;

    typedef struct {
        t_update   upd;
        bit        known;
        t_decision want;
    } t_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_WIDTH-1:0]       i_cfg_data;

    tmr_in_if  #(.VEL_WIDTH(VW), .TIME_WIDTH(TW)) in_if ();
    tmr_out_if #(.VEL_WIDTH(VW)) out_if ();

    track_motion_refine_core #(.VEL_WIDTH(VW), .TIME_WIDTH(TW)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    t_decision expected_motion [$];
    t_cfg      regs_now;
    int        updates_sent;
    int        decisions_seen;
    int        error_count;
    int        hold_requests;
    bit        steady;

    t_row directed_rows [$] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2'b00, 1'b0}, 1'b1, '{ACT_ZERO, 0, 0}},
        '{'{65536, 2000, 0, 0, 5000, 0, 123, -456, 1, 0, 2'b00, 1'b0}, 1'b1,
          '{ACT_KEEP, 123, -456}},
        '{'{65536, 2000, 0, 0, 5000, 0, 123, -456, 1, 0, 2'b00, 1'b1}, 1'b1,
          '{ACT_UNCHANGED, 5000, 0}},
        '{'{65536, 1000, 0, 0, 5000, 0, -7, 9, 1, 0, 2'b01, 1'b0}, 1'b1,
          '{ACT_KEEP, -7, 9}},
        '{'{65536, 1000, 0, 0, 5000, 0, -7, 9, 1, 0, 2'b00, 1'b0}, 1'b0,
          '{ACT_UNCHANGED, 0, 0}},
        '{'{-65536, -8388608, -8388608, -8388608, 5000, 0, 1, 1, 1, 0, 2'b00, 1'b0}, 1'b0,
          '{ACT_UNCHANGED, 0, 0}},
        '{'{32'sh7fffffff, -8388608, -8388608, -8388608, -8388608, -8388608,
            8388607, 8388607, -8388608, 8388607, 2'b11, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{32'sh80000000, 8388607, 8388607, 8388607, 8388607, -8388608,
            -8388608, 8388607, 8388607, -8388608, 2'b00, 1'b1}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 8388607, 0, 0, 5000, 0, 1, 1, 1, 0, 2'b00, 1'b0}, 1'b0,
          '{ACT_UNCHANGED, 0, 0}},
        '{'{1, 1, 0, 0, 5000, 0, 8388607, -8388608, 1, 0, 2'b00, 1'b0}, 1'b1,
          '{ACT_KEEP, 8388607, -8388608}},
        '{'{0, 0, 0, 0, 50, 0, 50, 0, 1, 0, 2'b00, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 50, 0, 50, 0, 1, 0, 2'b10, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 50, 0, 0, 0, 1, 0, 2'b10, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 50, 0, -50, 0, 1, 0, 2'b10, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 100, 0, 100, 100, 1, 0, 2'b10, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 100, 0, 100, 101, 1, 0, 2'b10, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 100, 0, 100, 10, 0, 0, 2'b10, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 100, 0, 100, 10, 0, 5, 2'b10, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 32, 0, 32, 0, 1, 0, 2'b10, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 31, 0, 31, 0, 1, 0, 2'b10, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 65536, 0, 65536, 0, 1, 0, 2'b00, 1'b0}, 1'b0,
          '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 255, 0, 0, 0, 1, 0, 2'b00, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 60, 0, 60, 30, 1, 0, 2'b10, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}},
        '{'{0, 0, 0, 0, 60, 0, 60, 40, 1, 0, 2'b10, 1'b0}, 1'b0, '{ACT_UNCHANGED, 0, 0}}
    };

    t_cfg phase_cfgs [N_PHASES] = '{
        '{16'd256, 16'd1280, 16'd1},
        '{16'd65535, 16'd65535, 16'd65535},
        '{16'd0, 16'd0, 16'd0},
        '{16'd4096, 16'd20, 16'd0},
        '{16'd1000, 16'd3000, 16'd600},
        '{16'd300, 16'd900, 16'd4},
        '{16'd65535, 16'd0, 16'd1},
        '{16'd12, 16'd65535, 16'd0}
    };

    function automatic logic [127:0] square(longint v);
        return 128'(v * v);
    endfunction

    function automatic bit past_limit(logic [127:0] asq, logic [127:0] bsq,
                                      logic [127:0] dm, bit narrow);
        logic [127:0] dd;
        logic [127:0] d;
        dd = dm * dm;
        d = asq * bsq - dd;
        if (narrow) d = d * 3;
        return d > dd;
    endfunction

    function automatic bit turned(longint nx, longint ny, longint px, longint py,
                                  longint hx, longint hy, bit narrow);
        logic [127:0] psq;
        logic [127:0] csq;
        logic [127:0] hsq;
        longint       dot;
        psq = square(px) + square(py);
        csq = square(nx) + square(ny);
        hsq = square(hx) + square(hy);
        if (psq == 0 || csq == 0) return 1'b1;
        dot = px * nx + py * ny;
        if (dot <= 0) return 1'b1;
        if (past_limit(psq, csq, 128'(dot), narrow)) return 1'b1;
        dot = hx * nx + hy * ny;
        return past_limit(hsq, csq, 128'(dot < 0 ? -dot : dot), narrow);
    endfunction

    function automatic bit under_level(logic [127:0] s2, int unsigned k,
                                       logic [CFG_WIDTH-1:0] v);
        logic [127:0] lim;
        lim = 128'(v);
        return s2 < (128'd1 << 32) && s2 * k * k < lim * lim;
    endfunction

    function automatic t_decision predict_motion(t_update u, t_cfg c);
        longint       t;
        longint       nx;
        longint       ny;
        logic [127:0] g2;
        logic [127:0] at;
        logic [127:0] rhs;
        logic [127:0] s2;
        bit           keep;
        bit           ped_prev;
        bit           lv8;
        bit           lv4;
        bit           lv2;
        bit           lv1;
        bit           zero;
        t_decision    r;
        t = longint'(u.time_delta);
        nx = longint'(u.new_velocity_x);
        ny = longint'(u.new_velocity_y);
        g2 = square(u.gain_x) + square(u.gain_y) + square(u.gain_z);
        keep = 1'b0;
        if (t >= 0 && t >= longint'(c.min_dt)) begin
            at = 128'(c.accel_thr) * 128'(t);
            rhs = at * at;
            keep = (g2 << ACC_SHIFT) > rhs ||
                   (u.pedestrian_flags[0] && (g2 << ACC_HALF_SHIFT) > rhs);
        end
        if (keep && !u.converged) begin
            r.action = ACT_KEEP;
            r.vx = u.prev_velocity_x;
            r.vy = u.prev_velocity_y;
            return r;
        end
        s2 = square(nx) + square(ny);
        ped_prev = u.pedestrian_flags[1];
        lv8 = under_level(s2, 8, c.speed_thr);
        lv4 = under_level(s2, 4, c.speed_thr);
        lv2 = under_level(s2, 2, c.speed_thr);
        lv1 = under_level(s2, 1, c.speed_thr);
        if (lv4 && !ped_prev) lv8 = 1'b1;
        zero = lv8;
        if (!zero) begin
            if (lv2 && !ped_prev) lv4 = 1'b1;
            zero = lv4 && turned(nx, ny, u.prev_velocity_x, u.prev_velocity_y,
                                 u.prev_direction_x, u.prev_direction_y, 1'b1);
        end
        if (!zero) begin
            if (lv1 && !ped_prev) lv2 = 1'b1;
            zero = lv2 && turned(nx, ny, u.prev_velocity_x, u.prev_velocity_y,
                                 u.prev_direction_x, u.prev_direction_y, 1'b0);
        end
        if (zero) begin
            r.action = ACT_ZERO;
            r.vx = '0;
            r.vy = '0;
        end else begin
            r.action = ACT_UNCHANGED;
            r.vx = u.new_velocity_x;
            r.vy = u.new_velocity_y;
        end
        return r;
    endfunction

    function automatic t_vel rand_vel(longint span);
        return t_vel'(longint'($urandom_range(32'(2 * span))) - span);
    endfunction

    function automatic t_update make_update(t_cfg c);
        t_update u;
        longint  span;
        longint  noise;
        longint  nx;
        longint  ny;
        case ($urandom_range(9))
            0: u.time_delta = $urandom;
            1: u.time_delta = '0;
            2: u.time_delta = TW'(longint'(c.min_dt) + longint'($urandom_range(2)) - 1);
            3: u.time_delta = TW'(-longint'($urandom_range(1 << 20, 1)));
            4: u.time_delta = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: u.time_delta = $urandom_range(1 << 18, 1 << 10);
        endcase
        span = longint'(c.accel_thr) * longint'(u.time_delta) / 65536;
        if (span < 0) span = -span;
        span = span * longint'($urandom_range(200, 40)) / 100;
        if (span > VEL_MAX) span = VEL_MAX;
        if ($urandom_range(3) == 0) begin
            u.gain_x = t_vel'($urandom);
            u.gain_y = t_vel'($urandom);
            u.gain_z = t_vel'($urandom);
        end else begin
            u.gain_x = rand_vel(span);
            u.gain_y = rand_vel(span);
            u.gain_z = rand_vel(span / 4);
        end

        span = longint'(c.speed_thr >> $urandom_range(4)) + 1;
        case ($urandom_range(7))
            0: begin
                u.new_velocity_x = t_vel'($urandom);
                u.new_velocity_y = t_vel'($urandom);
            end
            1: begin
                u.new_velocity_x = '0;
                u.new_velocity_y = '0;
            end
            2: begin
                span = longint'(1) << $urandom_range(VW - 2);
                u.new_velocity_x = rand_vel(span);
                u.new_velocity_y = rand_vel(span);
            end
            default: begin
                u.new_velocity_x = rand_vel(span);
                u.new_velocity_y = rand_vel(span);
            end
        endcase
        nx = longint'(u.new_velocity_x);
        ny = longint'(u.new_velocity_y);
        noise = (nx < 0 ? -nx : nx) + (ny < 0 ? -ny : ny);
        noise = (noise >> $urandom_range(5, 1)) + 1;
        if (noise > VEL_MAX) noise = VEL_MAX;

        case ($urandom_range(5))
            0: begin
                u.prev_velocity_x = '0;
                u.prev_velocity_y = '0;
            end
            1: begin
                u.prev_velocity_x = t_vel'($urandom);
                u.prev_velocity_y = t_vel'($urandom);
            end
            2: begin
                u.prev_velocity_x = $urandom_range(1) ? t_vel'(-ny) : t_vel'(-nx);
                u.prev_velocity_y = $urandom_range(1) ? t_vel'(nx) : t_vel'(-ny);
            end
            default: begin
                u.prev_velocity_x = t_vel'(nx + rand_vel(noise));
                u.prev_velocity_y = t_vel'(ny + rand_vel(noise));
            end
        endcase

        case ($urandom_range(5))
            0: begin
                u.prev_direction_x = '0;
                u.prev_direction_y = '0;
            end
            1: begin
                u.prev_direction_x = t_vel'($urandom);
                u.prev_direction_y = t_vel'($urandom);
            end
            2: begin
                u.prev_direction_x = u.prev_velocity_x;
                u.prev_direction_y = u.prev_velocity_y;
            end
            default: begin
                span = longint'($urandom_range(3, 1));
                u.prev_direction_x = t_vel'((nx + rand_vel(noise)) * span);
                u.prev_direction_y = t_vel'((ny + rand_vel(noise)) * span);
            end
        endcase
        u.pedestrian_flags = PED_WIDTH'($urandom);
        u.converged = 1'($urandom);
        return u;
    endfunction

    task automatic load_update(t_update u);
        in_if.time_delta       <= u.time_delta;
        in_if.gain_x           <= u.gain_x;
        in_if.gain_y           <= u.gain_y;
        in_if.gain_z           <= u.gain_z;
        in_if.new_velocity_x   <= u.new_velocity_x;
        in_if.new_velocity_y   <= u.new_velocity_y;
        in_if.prev_velocity_x  <= u.prev_velocity_x;
        in_if.prev_velocity_y  <= u.prev_velocity_y;
        in_if.prev_direction_x <= u.prev_direction_x;
        in_if.prev_direction_y <= u.prev_direction_y;
        in_if.pedestrian_flags <= u.pedestrian_flags;
        in_if.converged        <= u.converged;
    endtask

    // call at a rising edge; returns at the edge that takes the item
    task automatic send_update(t_update u, t_decision want);
        while (!steady && $urandom_range(99) < 21) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        load_update(u);
        @(negedge i_clk);
        while (!in_if.ready) @(negedge i_clk);
        @(posedge i_clk);
        expected_motion.push_back(want);
        updates_sent++;
    endtask

    task automatic drain_all();
        in_if.valid <= 1'b0;
        while (decisions_seen < updates_sent) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_SPEED_THR: regs_now.speed_thr = val;
            REG_ACCEL_THR: regs_now.accel_thr = val;
            REG_MIN_DT:    regs_now.min_dt = val;
            default: ;
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= steady || ($urandom_range(99) >= 21);
            end
        end
    end

    always @(posedge i_clk) begin
        t_decision want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            decisions_seen++;
            if (expected_motion.size() == 0) begin
                error_count++;
                $error("decision with no pending track update: action %0d",
                       out_if.action);
            end else begin
                want = expected_motion.pop_front();
                if (out_if.action !== want.action) begin
                    error_count++;
                    $error("action: expected %0d, got %0d", want.action, out_if.action);
                end
                if (out_if.out_velocity_x !== want.vx) begin
                    error_count++;
                    $error("out_velocity_x: expected %0d, got %0d",
                           want.vx, out_if.out_velocity_x);
                end
                if (out_if.out_velocity_y !== want.vy) begin
                    error_count++;
                    $error("out_velocity_y: expected %0d, got %0d",
                           want.vy, out_if.out_velocity_y);
                end
            end
        end
    end

    initial begin : stimulus
        t_update   upd;
        t_update   blank;
        t_decision want;
        blank = '{default: '0};
        updates_sent = 0;
        decisions_seen = 0;
        error_count = 0;
        hold_requests = 0;
        steady = 1'b0;
        regs_now = '{SPEED_THR_RST, ACCEL_THR_RST, MIN_DT_RST};
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_SPEED_THR;
        i_cfg_data  <= '0;
        in_if.valid <= 1'b0;
        load_update(blank);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            want = directed_rows[i].known ? directed_rows[i].want
                                          : predict_motion(directed_rows[i].upd, regs_now);
            send_update(directed_rows[i].upd, want);
        end

        phase_cfgs[5] = '{CFG_WIDTH'($urandom), CFG_WIDTH'($urandom), CFG_WIDTH'($urandom)};
        for (int p = 0; p < N_PHASES; p++) begin
            drain_all();
            write_reg(REG_UNUSED, CFG_WIDTH'($urandom));
            write_reg(REG_SPEED_THR, phase_cfgs[p].speed_thr);
            write_reg(REG_ACCEL_THR, phase_cfgs[p].accel_thr);
            write_reg(REG_MIN_DT, phase_cfgs[p].min_dt);
            i_cfg_we <= 1'b0;
            steady = (p == 2);
            if (p == 3) hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 5 && n == PHASE_ITEMS / 2) drain_all();
                upd = make_update(regs_now);
                send_update(upd, predict_motion(upd, regs_now));
            end
        end
        drain_all();

        if (expected_motion.size() != 0) begin
            error_count++;
            $error("%0d decisions never arrived", expected_motion.size());
        end
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
